FILE: hdl/hard_viterbi_decoder_terminated_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the hard-decision Viterbi decoder core
// Property wrappers; they expand to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef HARD_VITERBI_DECODER_TERMINATED_CORE_ASSERT_SVH
`define HARD_VITERBI_DECODER_TERMINATED_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HVD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hvd assertion failed");
// next-cycle implication
`define HVD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hvd assertion failed");
`else
`define HVD_ASSERT_IMP(lbl, ante, cons)
`define HVD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/hvd_pkg.sv
// ---------------------------------------------------------------------------
// hvd_pkg
// Shared types and constants of the hard-decision Viterbi decoder.
// ---------------------------------------------------------------------------
`default_nettype none
package hvd_pkg;

  // default sizes
  localparam int unsigned MAX_PAIRS_DEF   = 4096;
  localparam int unsigned STATE_COUNT_DEF = 64;

  // field widths
  localparam int unsigned POLY_W   = 7;
  localparam int unsigned SREG_W   = 6;
  localparam int unsigned TAIL_W   = 13;
  localparam int unsigned METRIC_W = 14;
  localparam int unsigned TIE_W    = 18;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned WBITS_W  = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;

  // register reset values
  localparam logic [POLY_W-1:0] POLY_FIRST_RST  = 7'd91;
  localparam logic [POLY_W-1:0] POLY_SECOND_RST = 7'd121;
  localparam logic [SREG_W-1:0] START_STATE_RST = 6'd0;
  localparam logic [SREG_W-1:0] END_STATE_RST   = 6'd0;
  localparam logic [TAIL_W-1:0] TAIL_BITS_RST   = 13'd6;

  // saturation limits
  localparam logic [METRIC_W-1:0] METRIC_CAP = 14'd8192;
  localparam logic [TIE_W-1:0]    TIE_CAP    = 18'd262143;

  // register indexes
  typedef enum logic [2:0] {
    REG_POLY_FIRST  = 3'd0,
    REG_POLY_SECOND = 3'd1,
    REG_START_STATE = 3'd2,
    REG_END_STATE   = 3'd3,
    REG_TAIL_BITS   = 3'd4
  } reg_idx_t;

  // frame status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 3'd0,
    STS_SHORT   = 3'd1,
    STS_UNREACH = 3'd2,
    STS_MISS    = 3'd3,
    STS_LONG    = 3'd4
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACS,
    ST_ACS_TAIL,
    ST_DEC_WR,
    ST_END_RD,
    ST_END_CHK,
    ST_TB_RD,
    ST_TB_USE,
    ST_EMIT_ONE,
    ST_OUT_RD,
    ST_OUT_EMIT
  } fsm_t;

endpackage
`default_nettype wire

FILE: hdl/hvd_ram.sv
// ---------------------------------------------------------------------------
// hvd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module hvd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/hard_viterbi_decoder_terminated_core.sv
// ---------------------------------------------------------------------------
// hard_viterbi_decoder_terminated_core
// Hard-decision Viterbi decoder for a terminated rate-1/2 code with erasure
// masks, memory-based path metrics, traceback and 64-bit payload output.
// ---------------------------------------------------------------------------
//  channel   handshake                   payload
//  input     start / busy                in_rx_*, in_seen_*, in_frame_end
//  result    out_strobe (no stall)       out_payload_word .. out_last_word
//  config    psel/penable/pwrite/pready  paddr, pwdata, prdata
//
//  The metric memory is read one predecessor pair per cycle, feeding two
//  add-compare-select units. Frame end reads and checks the end state's
//  metric; each traceback step reads the decision memory and then uses
//  it, and each result word is read from memory and then emitted.
//  rst_n is synchronous; no clearing pass, the first pair of a frame
//  overrides the metric memory contents. Results cannot be stalled.
// ---------------------------------------------------------------------------
`default_nettype none
`include "hard_viterbi_decoder_terminated_core_assert.svh"
module hard_viterbi_decoder_terminated_core #(
  parameter int unsigned MAX_PAIRS   = hvd_pkg::MAX_PAIRS_DEF,
  parameter int unsigned STATE_COUNT = hvd_pkg::STATE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_rx_first,
  input  logic                          in_rx_second,
  input  logic                          in_seen_first,
  input  logic                          in_seen_second,
  input  logic                          in_frame_end,
  // result channel
  output logic                          out_strobe,
  output logic [hvd_pkg::WORD_W-1:0]    out_payload_word,
  output logic [hvd_pkg::WBITS_W-1:0]   out_word_bits,
  output logic [hvd_pkg::STATUS_W-1:0]  out_status,
  output logic [hvd_pkg::METRIC_W-1:0]  out_final_metric,
  output logic [hvd_pkg::TIE_W-1:0]     out_tie_total,
  output logic                          out_last_word,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hvd_pkg::PADDR_W-1:0]   paddr,
  input  logic [hvd_pkg::PDATA_W-1:0]   pwdata,
  output logic [hvd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import hvd_pkg::*;

  localparam int unsigned SB   = $clog2(STATE_COUNT);
  localparam int unsigned HALF = STATE_COUNT / 2;
  localparam int unsigned QTR  = STATE_COUNT / 4;
  localparam int unsigned JW   = SB - 1;
  localparam int unsigned KW   = (SB > 2) ? SB - 2 : 1;
  localparam int unsigned MD   = 2 << KW;
  localparam int unsigned MAW  = KW + 1;
  localparam int unsigned EW   = METRIC_W + 1;
  localparam int unsigned PW   = $clog2(MAX_PAIRS + 1);
  localparam int unsigned AW   = $clog2(MAX_PAIRS);
  localparam int unsigned WD   = (MAX_PAIRS / 64 < 2) ? 2 : MAX_PAIRS / 64;
  localparam int unsigned WA   = $clog2(WD);
  localparam int unsigned RW   = (SB + 1 > POLY_W) ? SB + 1 : POLY_W;

  // branch metric of one trellis edge
  function automatic logic [1:0] bmet(input logic [SB:0] r, input logic [POLY_W-1:0] pf,
                                      input logic [POLY_W-1:0] ps, input logic rx1,
                                      input logic rx2, input logic sn1, input logic sn2);
    logic c1;
    logic c2;
    c1 = ^(RW'(r) & RW'(pf));
    c2 = ^(RW'(r) & RW'(ps));
    return {1'b0, sn1 & (rx1 ^ c1)} + {1'b0, sn2 & (rx2 ^ c2)};
  endfunction

  // configuration registers
  logic [POLY_W-1:0] poly_first_r, poly_second_r;
  logic [SREG_W-1:0] start_state_r, end_state_r;
  logic [TAIL_W-1:0] tail_bits_r;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  // control and datapath registers
  fsm_t                state_r, state_nxt;
  logic [JW-1:0]       j_r, jd_r;
  logic                pv_r;
  logic                bank_r;
  logic [METRIC_W-1:0] min_r, nmin_r;
  logic                nany_r;
  logic [SB-1:0]       fs_r;
  logic [PW-1:0]       pcnt_r;
  logic                tl_r, fe_r;
  logic                rx1_r, rx2_r, sn1_r, sn2_r;
  logic [EW-1:0]       ev_r [2];
  logic [STATE_COUNT-1:0] dec_r, val_r;
  logic [TIE_W-1:0]    tie_r;
  status_t             status_r;
  logic [METRIC_W-1:0] fmet_r;
  logic [SB-1:0]       tb_s_r;
  logic [PW-1:0]       tb_t_r;
  logic [WORD_W-1:0]   wacc_r;
  logic [TAIL_W-1:0]   len_r;
  logic [WBITS_W-1:0]  nwords_r, w_r;

  // memory ports
  logic                  met_we;
  logic [MAW-1:0]        met_waddr, met_raddr;
  logic [2*EW-1:0]       lo_wdata, hi_wdata, lo_rdata, hi_rdata;
  logic                  dec_we;
  logic [AW-1:0]         dec_raddr;
  logic [2*STATE_COUNT-1:0] dec_rdata;
  logic                  wrd_we;
  logic [WA-1:0]         wrd_waddr, wrd_raddr;
  logic [WORD_W-1:0]     wrd_wdata, wrd_rdata;

  // ACS signals
  logic                  accept, fresh;
  logic [2*EW-1:0]       pair;
  logic [SB-1:0]         pst [2];
  logic                  prch [2];
  logic [METRIC_W-1:0]   pmet [2];
  logic [METRIC_W:0]     csum;
  logic [METRIC_W-1:0]   cand [2][2];
  logic [METRIC_W-1:0]   best [2];
  logic                  nval [2], dbit [2], tie [2];
  logic [EW-1:0]         nent [2];
  logic [METRIC_W-1:0]   nmin_nxt;
  logic                  nany_nxt;
  logic [TIE_W:0]        tie_sum;
  logic [TIE_W-1:0]      tie_nxt;

  // end state and traceback signals
  logic [SB-1:0]         es;
  logic [EW-1:0]         eent;
  logic [METRIC_W-1:0]   emet;
  logic                  short_frame;
  logic [TAIL_W-1:0]     len_calc;
  logic [PW-1:0]         tm1;
  logic                  tb_vbit, tb_dbit;
  logic [SB-1:0]         tb_s_nxt;
  logic [WORD_W-1:0]     wacc_nxt;
  logic                  tb_last;

  // output word signals
  logic [TAIL_W-1:0]     rem;
  logic [WBITS_W-1:0]    cnt;
  logic [WORD_W-1:0]     wmask;
  logic                  wlast;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign fresh  = (pcnt_r == '0);
  assign es     = SB'(end_state_r);

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_first_r  <= POLY_FIRST_RST;
      poly_second_r <= POLY_SECOND_RST;
      start_state_r <= START_STATE_RST;
      end_state_r   <= END_STATE_RST;
      tail_bits_r   <= TAIL_BITS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_POLY_FIRST:  poly_first_r  <= pwdata[POLY_W-1:0];
        REG_POLY_SECOND: poly_second_r <= pwdata[POLY_W-1:0];
        REG_START_STATE: start_state_r <= pwdata[SREG_W-1:0];
        REG_END_STATE:   end_state_r   <= pwdata[SREG_W-1:0];
        REG_TAIL_BITS:   tail_bits_r   <= pwdata[TAIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_POLY_FIRST:  prdata = PDATA_W'(poly_first_r);
      REG_POLY_SECOND: prdata = PDATA_W'(poly_second_r);
      REG_START_STATE: prdata = PDATA_W'(start_state_r);
      REG_END_STATE:   prdata = PDATA_W'(end_state_r);
      REG_TAIL_BITS:   prdata = PDATA_W'(tail_bits_r);
      default:         prdata = '0;
    endcase
  end

  // path metric memories: low half and high half of the states, two states
  // per entry, two banks for old and new metrics
  hvd_ram #(.WIDTH(2*EW), .DEPTH(MD)) u_met_lo (
    .clk(clk), .we(met_we), .waddr(met_waddr), .wdata(lo_wdata),
    .raddr(met_raddr), .rdata(lo_rdata)
  );
  hvd_ram #(.WIDTH(2*EW), .DEPTH(MD)) u_met_hi (
    .clk(clk), .we(met_we), .waddr(met_waddr), .wdata(hi_wdata),
    .raddr(met_raddr), .rdata(hi_rdata)
  );

  // survivor decisions and valid flags, one row per pair
  hvd_ram #(.WIDTH(2*STATE_COUNT), .DEPTH(MAX_PAIRS)) u_dec (
    .clk(clk), .we(dec_we), .waddr(pcnt_r[AW-1:0]), .wdata({val_r, dec_r}),
    .raddr(dec_raddr), .rdata(dec_rdata)
  );

  // decoded payload words
  hvd_ram #(.WIDTH(WORD_W), .DEPTH(WD)) u_wrd (
    .clk(clk), .we(wrd_we), .waddr(wrd_waddr), .wdata(wrd_wdata),
    .raddr(wrd_raddr), .rdata(wrd_rdata)
  );

  // metric read address: predecessor pair j, or the end state's pair
  always_comb begin
    if (state_r == ST_END_RD) begin
      met_raddr = {bank_r, KW'(es[SB-1:1] & JW'(QTR - 1))};
    end else begin
      met_raddr = {bank_r, KW'(j_r & JW'(QTR - 1))};
    end
  end

  // add-compare-select for targets jd and jd+HALF
  always_comb begin
    pair = jd_r[JW-1] ? hi_rdata : lo_rdata;
    pst[0] = {jd_r, 1'b0};
    pst[1] = {jd_r, 1'b1};
    for (int d = 0; d < 2; d++) begin
      if (fresh) begin
        prch[d] = (pst[d] == fs_r);
        pmet[d] = '0;
      end else begin
        prch[d] = pair[d*EW + EW - 1];
        pmet[d] = pair[d*EW +: METRIC_W] - min_r;
      end
    end
    for (int g = 0; g < 2; g++) begin
      for (int d = 0; d < 2; d++) begin
        csum = {1'b0, pmet[d]} + (METRIC_W + 1)'(bmet({g[0], pst[d]}, poly_first_r,
               poly_second_r, rx1_r, rx2_r, sn1_r, sn2_r));
        cand[g][d] = (csum > {1'b0, METRIC_CAP}) ? METRIC_CAP : csum[METRIC_W-1:0];
      end
      nval[g] = prch[0] || prch[1];
      tie[g]  = prch[0] && prch[1] && (cand[g][0] == cand[g][1]);
      if (prch[0] && (!prch[1] || cand[g][0] <= cand[g][1])) begin
        dbit[g] = 1'b0;
        best[g] = cand[g][0];
      end else if (prch[1]) begin
        dbit[g] = 1'b1;
        best[g] = cand[g][1];
      end else begin
        dbit[g] = 1'b0;
        best[g] = '0;
      end
      nent[g] = {nval[g], best[g]};
    end
  end

  // running minimum of the new metrics
  always_comb begin
    nmin_nxt = nmin_r;
    nany_nxt = nany_r;
    for (int g = 0; g < 2; g++) begin
      if (nval[g] && (!nany_nxt || best[g] < nmin_nxt)) begin
        nmin_nxt = best[g];
        nany_nxt = 1'b1;
      end
    end
  end

  // saturating tie count
  always_comb begin
    tie_sum = {1'b0, tie_r} + (TIE_W + 1)'({1'b0, tie[0]} + {1'b0, tie[1]});
    tie_nxt = (tie_sum > {1'b0, TIE_CAP}) ? TIE_CAP : tie_sum[TIE_W-1:0];
  end

  // metric write-back once both states of a pair are done
  assign met_we    = pv_r && jd_r[0];
  assign met_waddr = {!bank_r, KW'(jd_r >> 1)};
  assign lo_wdata  = {nent[0], ev_r[0]};
  assign hi_wdata  = {nent[1], ev_r[1]};
  assign dec_we    = (state_r == ST_DEC_WR);

  // end state lookup
  always_comb begin
    eent = es[0] ? (es[SB-1] ? hi_rdata[2*EW-1:EW] : lo_rdata[2*EW-1:EW])
                 : (es[SB-1] ? hi_rdata[EW-1:0] : lo_rdata[EW-1:0]);
    emet = eent[METRIC_W-1:0] - min_r;
    short_frame = (TAIL_W'(pcnt_r) < tail_bits_r);
    len_calc = TAIL_W'(pcnt_r) - tail_bits_r;
  end

  // traceback step
  always_comb begin
    tm1       = tb_t_r - PW'(1);
    dec_raddr = AW'(tm1);
    tb_dbit   = dec_rdata[tb_s_r];
    tb_vbit   = dec_rdata[{1'b1, tb_s_r}];
    tb_s_nxt  = SB'({tb_s_r, tb_dbit});
    wacc_nxt  = wacc_r;
    wacc_nxt[tm1[5:0]] = tb_s_r[SB-1];
    tb_last   = (tb_t_r == PW'(1));
    wrd_we    = (state_r == ST_TB_USE) && tb_vbit && (tm1[5:0] == 6'd0);
    wrd_waddr = WA'(tm1 >> 6);
    wrd_wdata = wacc_nxt;
    wrd_raddr = WA'(w_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (pcnt_r < PW'(MAX_PAIRS)) begin
            state_nxt = ST_ACS;
          end else if (in_frame_end) begin
            state_nxt = ST_END_RD;
          end
        end
      end
      ST_ACS: begin
        if (j_r == JW'(HALF - 1)) begin
          state_nxt = ST_ACS_TAIL;
        end
      end
      ST_ACS_TAIL: state_nxt = ST_DEC_WR;
      ST_DEC_WR:   state_nxt = fe_r ? ST_END_RD : ST_IDLE;
      ST_END_RD:   state_nxt = ST_END_CHK;
      ST_END_CHK: begin
        if (!tl_r && eent[EW-1] && !short_frame) begin
          state_nxt = ST_TB_RD;
        end else begin
          state_nxt = ST_EMIT_ONE;
        end
      end
      ST_TB_RD: state_nxt = ST_TB_USE;
      ST_TB_USE: begin
        priority if (!tb_vbit) begin
          state_nxt = ST_EMIT_ONE;
        end else if (tb_last) begin
          if (tb_s_nxt != fs_r || nwords_r == '0) begin
            state_nxt = ST_EMIT_ONE;
          end else begin
            state_nxt = ST_OUT_RD;
          end
        end else begin
          state_nxt = ST_TB_RD;
        end
      end
      ST_EMIT_ONE: state_nxt = ST_IDLE;
      ST_OUT_RD:   state_nxt = ST_OUT_EMIT;
      ST_OUT_EMIT: state_nxt = wlast ? ST_IDLE : ST_OUT_RD;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rem   = len_r - (TAIL_W'(w_r) << 6);
    cnt   = (rem > TAIL_W'(64)) ? WBITS_W'(64) : WBITS_W'(rem);
    wmask = (cnt == WBITS_W'(64)) ? '1 : ((WORD_W'(1) << cnt) - WORD_W'(1));
    wlast = ((w_r + WBITS_W'(1)) == nwords_r);
    out_strobe       = (state_r == ST_EMIT_ONE) || (state_r == ST_OUT_EMIT);
    out_payload_word = (state_r == ST_OUT_EMIT) ? (wrd_rdata & wmask) : '0;
    out_word_bits    = (state_r == ST_OUT_EMIT) ? cnt : '0;
    out_status       = status_r;
    out_final_metric = fmet_r;
    out_tie_total    = tie_r;
    out_last_word    = (state_r == ST_EMIT_ONE) || wlast;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pcnt_r  <= '0;
      tie_r   <= '0;
      tl_r    <= 1'b0;
      pv_r    <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= (state_r == ST_ACS);
      if (accept && !(pcnt_r < PW'(MAX_PAIRS))) begin
        tl_r <= 1'b1;
      end
      if (pv_r) begin
        tie_r <= tie_nxt;
      end
      if (state_r == ST_DEC_WR) begin
        pcnt_r <= pcnt_r + PW'(1);
        bank_r <= !bank_r;
      end
      if ((state_r == ST_EMIT_ONE) || (state_r == ST_OUT_EMIT && wlast)) begin
        pcnt_r <= '0;
        tie_r  <= '0;
        tl_r   <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    jd_r <= j_r;
    if (accept) begin
      j_r    <= '0;
      nany_r <= 1'b0;
      nmin_r <= '0;
      rx1_r  <= in_rx_first;
      rx2_r  <= in_rx_second;
      sn1_r  <= in_seen_first;
      sn2_r  <= in_seen_second;
      fe_r   <= in_frame_end;
      if (fresh) begin
        fs_r <= SB'(start_state_r);
      end
    end
    if (state_r == ST_ACS) begin
      j_r <= j_r + JW'(1);
    end
    if (pv_r) begin
      nmin_r <= nmin_nxt;
      nany_r <= nany_nxt;
      dec_r[SB'(jd_r)]       <= dbit[0];
      dec_r[{1'b1, jd_r}]    <= dbit[1];
      val_r[SB'(jd_r)]       <= nval[0];
      val_r[{1'b1, jd_r}]    <= nval[1];
      if (!jd_r[0]) begin
        ev_r[0] <= nent[0];
        ev_r[1] <= nent[1];
      end
    end
    if (state_r == ST_DEC_WR) begin
      min_r <= nany_r ? nmin_r : '0;
    end
    if (state_r == ST_END_CHK) begin
      tb_s_r   <= es;
      tb_t_r   <= pcnt_r;
      len_r    <= len_calc;
      nwords_r <= WBITS_W'((len_calc + TAIL_W'(63)) >> 6);
      w_r      <= '0;
      priority if (tl_r) begin
        status_r <= STS_LONG;
        fmet_r   <= '0;
      end else if (!eent[EW-1]) begin
        status_r <= short_frame ? STS_SHORT : STS_UNREACH;
        fmet_r   <= '0;
      end else begin
        status_r <= short_frame ? STS_SHORT : STS_OK;
        fmet_r   <= emet;
      end
    end
    if (state_r == ST_TB_USE) begin
      tb_s_r <= tb_s_nxt;
      tb_t_r <= tm1;
      wacc_r <= wacc_nxt;
      if (!tb_vbit || (tb_last && tb_s_nxt != fs_r)) begin
        status_r <= STS_MISS;
      end
    end
    if (state_r == ST_OUT_EMIT) begin
      w_r <= w_r + WBITS_W'(1);
    end
  end

  // checks
  `HVD_ASSERT_IMP(a_strobe_busy, out_strobe, busy)
  `HVD_ASSERT_NXT(a_last_idle, out_strobe && out_last_word, !busy)
  `HVD_ASSERT_IMP(a_dec_wr_range, dec_we, pcnt_r < PW'(MAX_PAIRS))
  `HVD_ASSERT_IMP(a_met_wr_phase, met_we, state_r == ST_ACS || state_r == ST_ACS_TAIL)

endmodule
`default_nettype wire

FILE: sim/tb_hard_viterbi_decoder_terminated_core.sv
// ---------------------------------------------------------------------------
// Viterbi decoder core testbench
// Feeds encoded frames (clean, noisy, erased and raw) through the decoder over
// several register settings and checks every payload word, status, metric and
// tie count against an in-bench trellis decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_hard_viterbi_decoder_terminated_core;
  import hvd_pkg::*;

  localparam int unsigned PAIR_DEPTH = 4096;
  localparam int unsigned N_STATES   = 64;
  localparam int unsigned RUN_LIMIT  = 3000000;

  typedef struct {
    bit [63:0] payload;
    bit [6:0]  nbits;
    bit [2:0]  sts;
    bit [13:0] metric;
    bit [17:0] ties;
    bit        last;
  } word_t;

  typedef struct {
    bit rx1;
    bit rx2;
    bit sn1;
    bit sn2;
    bit fe;
  } pair_t;

  // trellis decoder model and expected word store
  class decoder_scoreboard;
    bit [6:0]    poly_a;
    bit [6:0]    poly_b;
    bit [5:0]    start_st;
    bit [5:0]    end_st;
    bit [12:0]   tail_len;
    int unsigned metric[N_STATES];
    bit          reach[N_STATES];
    bit [63:0]   dec_mem[PAIR_DEPTH];
    bit [63:0]   surv_mem[PAIR_DEPTH];
    bit          dec_bit[PAIR_DEPTH];
    int unsigned pairs;
    int unsigned ties;
    bit          overrun;
    bit [5:0]    first_st;
    word_t       word_q[$];
    int unsigned errors;

    function new();
      poly_a   = POLY_FIRST_RST;
      poly_b   = POLY_SECOND_RST;
      start_st = START_STATE_RST;
      end_st   = END_STATE_RST;
      tail_len = TAIL_BITS_RST;
      pairs    = 0;
      ties     = 0;
      overrun  = 0;
      errors   = 0;
      open_frame();
    endfunction

    function void set_reg(reg_idx_t idx, bit [31:0] v);
      case (idx)
        REG_POLY_FIRST:  poly_a = v[6:0];
        REG_POLY_SECOND: poly_b = v[6:0];
        REG_START_STATE: start_st = v[5:0];
        REG_END_STATE:   end_st = v[5:0];
        REG_TAIL_BITS:   tail_len = v[12:0];
        default: ;
      endcase
    endfunction

    function void open_frame();
      first_st = start_st;
      for (int s = 0; s < N_STATES; s++) begin
        metric[s] = 0;
        reach[s]  = (s == first_st);
      end
    endfunction

    // add-compare-select over all states for one pair
    function void acs(int unsigned t, bit rx1, bit rx2, bit sn1, bit sn2);
      int unsigned nm[N_STATES];
      bit          nr[N_STATES];
      int unsigned best, c, bm, minm;
      bit          bd, ok, any;
      bit [5:0]    p;
      bit [6:0]    r;
      any  = 0;
      minm = METRIC_CAP;
      for (int ns = 0; ns < N_STATES; ns++) begin
        best = 0;
        bd   = 0;
        ok   = 0;
        for (int d = 0; d < 2; d++) begin
          p = {ns[4:0], d[0]};
          if (!reach[p]) continue;
          r  = {ns[5], p};
          bm = (sn1 && (rx1 != ^(r & poly_a))) + (sn2 && (rx2 != ^(r & poly_b)));
          c  = metric[p] + bm;
          if (c > METRIC_CAP) c = METRIC_CAP;
          if (ok && c == best && ties < TIE_CAP) ties++;
          if (!ok || c < best) begin
            best = c;
            bd   = d[0];
            ok   = 1;
          end
        end
        nm[ns] = best;
        nr[ns] = ok;
        dec_mem[t][ns]  = bd;
        surv_mem[t][ns] = ok;
        if (ok && (!any || best < minm)) begin
          minm = best;
          any  = 1;
        end
      end
      for (int ns = 0; ns < N_STATES; ns++) begin
        metric[ns] = nr[ns] ? nm[ns] - (any ? minm : 0) : 0;
        reach[ns]  = nr[ns];
      end
    endfunction

    function void push_word(bit [63:0] w, int unsigned n, status_t st,
                            int unsigned m, bit last);
      word_t e;
      e.payload = w;
      e.nbits   = n[6:0];
      e.sts     = st;
      e.metric  = m[13:0];
      e.ties    = ties[17:0];
      e.last    = last;
      word_q.push_back(e);
    endfunction

    // one accepted pair; at frame end trace back and queue the words
    function void note_pair(pair_t pr);
      status_t     st;
      int unsigned m, len, words, cnt;
      bit [5:0]    s;
      bit [63:0]   w;
      if (pairs == 0 && !overrun) open_frame();
      if (pairs < PAIR_DEPTH) begin
        acs(pairs, pr.rx1, pr.rx2, pr.sn1, pr.sn2);
        pairs++;
      end else begin
        overrun = 1;
      end
      if (!pr.fe) return;
      st = STS_OK;
      m  = 0;
      s  = end_st;
      if (overrun) begin
        st = STS_LONG;
      end else if (!reach[s]) begin
        st = (pairs < tail_len) ? STS_SHORT : STS_UNREACH;
      end else begin
        m = metric[s];
        if (pairs < tail_len) begin
          st = STS_SHORT;
        end else begin
          for (int t = pairs; t > 0; t--) begin
            if (!surv_mem[t-1][s]) begin
              st = STS_MISS;
              break;
            end
            dec_bit[t-1] = s[5];
            s = {s[4:0], dec_mem[t-1][s]};
          end
          if (st == STS_OK && s != first_st) st = STS_MISS;
        end
      end
      if (st != STS_OK) begin
        push_word(0, 0, st, m, 1);
      end else begin
        len   = pairs - tail_len;
        words = (len + 63) / 64;
        if (words == 0) push_word(0, 0, STS_OK, m, 1);
        for (int k = 0; k < words; k++) begin
          cnt = len - k * 64;
          if (cnt > 64) cnt = 64;
          w = 0;
          for (int i = 0; i < cnt; i++) w[i] = dec_bit[k*64 + i];
          push_word(w, cnt, STS_OK, m, k + 1 == words);
        end
      end
      pairs   = 0;
      ties    = 0;
      overrun = 0;
    endfunction

    function void check_word(word_t got);
      word_t e;
      if (word_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result word %h", got.payload);
        return;
      end
      e = word_q.pop_front();
      if (e != got) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: exp word %h bits %0d sts %0d met %0d tie %0d last %0b / got %h %0d %0d %0d %0d %0b",
                   e.payload, e.nbits, e.sts, e.metric, e.ties, e.last,
                   got.payload, got.nbits, got.sts, got.metric, got.ties, got.last);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_rx_first, in_rx_second, in_seen_first, in_seen_second;
  logic                in_frame_end;
  logic                out_strobe;
  logic [WORD_W-1:0]   out_payload_word;
  logic [WBITS_W-1:0]  out_word_bits;
  logic [STATUS_W-1:0] out_status;
  logic [METRIC_W-1:0] out_final_metric;
  logic [TIE_W-1:0]    out_tie_total;
  logic                out_last_word;
  logic                psel, penable, pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  decoder_scoreboard sb = new();
  pair_t             frame_q[$];
  bit                no_gaps;
  int unsigned       cycles;

  hard_viterbi_decoder_terminated_core u_top (
    .clk, .rst_n, .start, .busy,
    .in_rx_first, .in_rx_second, .in_seen_first, .in_seen_second, .in_frame_end,
    .out_strobe, .out_payload_word, .out_word_bits, .out_status,
    .out_final_metric, .out_tie_total, .out_last_word,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result monitor
  always @(posedge clk) begin
    word_t got;
    if (rst_n && out_strobe) begin
      got.payload = out_payload_word;
      got.nbits   = out_word_bits;
      got.sts     = out_status;
      got.metric  = out_final_metric;
      got.ties    = out_tie_total;
      got.last    = out_last_word;
      sb.check_word(got);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one pair transfer; start stays high across back-to-back pairs
  task automatic send_pair(pair_t pr);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      start = 1'b0;
      @(negedge clk);
    end
    start          = 1'b1;
    in_rx_first    = pr.rx1;
    in_rx_second   = pr.rx2;
    in_seen_first  = pr.sn1;
    in_seen_second = pr.sn2;
    in_frame_end   = pr.fe;
    do @(posedge clk); while (busy);
    sb.note_pair(pr);
    @(negedge clk);
  endtask

  task automatic send_frame();
    no_gaps = ($urandom_range(0, 3) == 0);
    foreach (frame_q[i]) send_pair(frame_q[i]);
    frame_q.delete();
  endtask

  // hold off until the decoder has drained
  task automatic drain();
    start = 1'b0;
    while (sb.word_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [31:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'(idx * 4);
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(bit [6:0] pa, bit [6:0] pb, bit [5:0] ss, bit [5:0] es,
                           bit [12:0] tl);
    drain();
    write_reg(REG_POLY_FIRST, {$urandom} << 7 | pa);
    write_reg(REG_POLY_SECOND, {$urandom} << 7 | pb);
    write_reg(REG_START_STATE, {$urandom} << 6 | ss);
    write_reg(REG_END_STATE, {$urandom} << 6 | es);
    write_reg(REG_TAIL_BITS, {$urandom} << 13 | tl);
  endtask

  // encode plen random bits plus a tail that lands on the end state,
  // then flip or erase code bits at noise_pct percent
  task automatic make_coded(int plen, int noise_pct);
    bit [5:0] st;
    bit [6:0] r;
    bit       u;
    pair_t    pr;
    st = sb.start_st;
    for (int i = 0; i < plen + 6; i++) begin
      u = (i < plen) ? $urandom_range(0, 1) : sb.end_st[i - plen];
      r = {u, st};
      pr.rx1 = ^(r & sb.poly_a);
      pr.rx2 = ^(r & sb.poly_b);
      pr.sn1 = 1'b1;
      pr.sn2 = 1'b1;
      if ($urandom_range(0, 99) < noise_pct) pr.rx1 = ~pr.rx1;
      if ($urandom_range(0, 99) < noise_pct) pr.rx2 = ~pr.rx2;
      if ($urandom_range(0, 99) < noise_pct) pr.sn1 = 1'b0;
      if ($urandom_range(0, 99) < noise_pct) pr.sn2 = 1'b0;
      pr.fe = (i == plen + 5);
      frame_q.push_back(pr);
      st = r[6:1];
    end
  endtask

  task automatic make_raw(int n);
    pair_t pr;
    for (int i = 0; i < n; i++) begin
      pr.rx1 = $urandom_range(0, 1);
      pr.rx2 = $urandom_range(0, 1);
      pr.sn1 = $urandom_range(0, 1);
      pr.sn2 = $urandom_range(0, 1);
      pr.fe  = (i == n - 1);
      frame_q.push_back(pr);
    end
  endtask

  // random frames, mostly well-formed
  task automatic random_frames(int n_items);
    int sent;
    int sel;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) make_raw($urandom_range(1, 20));
      else if (sel == 2) make_coded($urandom_range(100, 200), $urandom_range(0, 4));
      else make_coded($urandom_range(1, 70), $urandom_range(0, 8));
      sent += frame_q.size();
      send_frame();
    end
  endtask

  initial begin
    pair_t pr;
    cycles         = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_rx_first    = 1'b0;
    in_rx_second   = 1'b0;
    in_seen_first  = 1'b0;
    in_seen_second = 1'b0;
    in_frame_end   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    no_gaps        = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: lone pair shorter than tail, clean frame, erased pair
    pr = '{rx1: 1, rx2: 1, sn1: 1, sn2: 1, fe: 1};
    frame_q.push_back(pr);
    send_frame();
    make_coded(10, 0);
    send_frame();
    pr = '{rx1: 1, rx2: 0, sn1: 0, sn2: 0, fe: 0};
    frame_q.push_back(pr);
    make_coded(3, 0);
    send_frame();

    // directed: no tail, end state unreachable in a two-pair and a one-pair frame
    configure(POLY_FIRST_RST, POLY_SECOND_RST, 6'd0, 6'd63, 13'd0);
    make_raw(2);
    send_frame();
    make_raw(1);
    send_frame();

    // directed: tail longer than any frame, extreme polynomials
    configure(7'd127, 7'd0, 6'd63, 6'd0, 13'd4096);
    make_coded(5, 0);
    send_frame();
    configure(7'd0, 7'd127, 6'd0, 6'd63, 13'd6);
    make_coded(8, 0);
    send_frame();

    // random phases over several settings
    configure(POLY_FIRST_RST, POLY_SECOND_RST, 6'd0, 6'd0, 13'd6);
    random_frames(120);
    configure(7'd127, 7'd127, 6'd63, 6'd63, 13'd6);
    random_frames(80);
    configure($urandom, $urandom, $urandom, $urandom, 13'd6);
    random_frames(80);
    configure(POLY_FIRST_RST, POLY_SECOND_RST, $urandom, $urandom,
              $urandom_range(0, 12));
    random_frames(80);
    configure(7'd109, 7'd79, $urandom, $urandom, 13'd6);
    random_frames(120);

    // overlong frame: one pair past the survivor depth
    make_raw(PAIR_DEPTH + 1);
    send_frame();
    make_coded(20, 0);
    send_frame();

    drain();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
